@@ hw/rtl/ehr_pkg.sv @@
// ----------------------------------------------------------------------------
// ehr_pkg
// Shared types and constants for the Econet handshake receiver.
// ----------------------------------------------------------------------------
package ehr_pkg;

    localparam logic [1:0] ACT_ACK     = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_DELIVER = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    localparam logic [2:0] REG_OWN_ADDRESS    = 3'd0;
    localparam logic [2:0] REG_WANTED_STATION = 3'd1;
    localparam logic [2:0] REG_WANTED_NETWORK = 3'd2;
    localparam logic [2:0] REG_WANTED_PORT    = 3'd3;
    localparam logic [2:0] REG_RETRY_LIMIT    = 3'd4;
    localparam logic [2:0] REG_PEEK_REPLY     = 3'd5;

    localparam logic [7:0]  PEEK_CTL        = 8'h88;
    localparam logic [15:0] SCOUT_LEN       = 16'd6;
    localparam logic [15:0] HDR_LEN         = 16'd4;
    localparam logic [15:0] OWN_ADDR_RESET  = 16'd254;
    localparam logic [7:0]  RETRY_RESET     = 8'd50;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic PHASE_IDLE = 1'b0;
    localparam logic PHASE_DATA = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  peer_station;
        logic [7:0]  peer_network;
        logic [7:0]  control;
        logic [7:0]  port;
        logic [15:0] data_length;
        logic [31:0] reply_data;
        logic        last;
    } res_t;

endpackage

@@ hw/rtl/econet_handshake_receiver.sv @@
// ----------------------------------------------------------------------------
// econet_handshake_receiver
// Receiver side of the Econet four-way handshake: immediate replies,
// scout acknowledge, data frame delivery and retry timeout.
// ----------------------------------------------------------------------------
//  channel  | ports          | carries
//  ---------+----------------+------------------------------------------
//  input    | s_valid/s_ready| frame header or listen-timeout tick
//  result   | m_valid/m_ready| ack, immediate reply, delivery, timeout
//  config   | cfg_wr_en      | register write, no wait, no read-back
//
//  One request is decoded in the cycle it is accepted; its zero, one or
//  two results are registered into a four-entry result queue and leave in order.
//  A request is taken every cycle while the queue has room for two results.
//  Reset is synchronous: state, queue and registers return to defaults.
//  A stalled result side fills the queue until under two entries are free, then holds s_ready low.
// ----------------------------------------------------------------------------
module econet_handshake_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_dest_station,
    input  logic [7:0]  s_dest_network,
    input  logic [7:0]  s_src_station,
    input  logic [7:0]  s_src_network,
    input  logic [7:0]  s_ctl_byte,
    input  logic [7:0]  s_port_byte,
    input  logic [15:0] s_frame_length,
    input  logic        s_source_verified,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [7:0]  m_peer_station,
    output logic [7:0]  m_peer_network,
    output logic [7:0]  m_control,
    output logic [7:0]  m_port,
    output logic [15:0] m_data_length,
    output logic [31:0] m_reply_data,
    output logic        m_last
);
    import ehr_pkg::*;

    logic [15:0] own_address_reg;
    logic [7:0]  wanted_station_reg;
    logic [7:0]  wanted_network_reg;
    logic [7:0]  wanted_port_reg;
    logic [7:0]  retry_limit_reg;
    logic [31:0] peek_reply_reg;

    logic        phase_reg, phase_next;
    logic [7:0]  retries_reg, retries_next;
    logic [15:0] peer_reg, peer_next;
    logic [7:0]  scout_ctl_reg, scout_ctl_next;
    logic [7:0]  scout_port_reg, scout_port_next;

    res_t                fifo_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    logic        accept, pop;
    logic [1:0]  res_cnt;
    res_t        res0, res1;
    logic [15:0] src_addr;
    logic        frame_ok, forever_mode, rejected, spend, exhausted;
    res_t        head;

    assign accept   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;
    assign s_ready  = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
    assign m_valid  = count_reg != '0;
    assign src_addr = {s_src_network, s_src_station};

    always_comb begin
        frame_ok     = !s_command && (s_frame_length >= HDR_LEN)
                       && ({s_dest_network, s_dest_station} == own_address_reg)
                       && s_source_verified;
        forever_mode = (wanted_station_reg == 8'd0) && (wanted_network_reg == 8'd0);
        rejected     = (!forever_mode && src_addr != {wanted_network_reg, wanted_station_reg})
                       || (wanted_port_reg != 8'd0 && wanted_port_reg != s_port_byte)
                       || (s_frame_length != SCOUT_LEN);
        exhausted    = retries_reg <= 8'd1;
        spend        = 1'b0;
        res_cnt      = 2'd0;
        res0         = '0;
        res1         = '0;
        phase_next      = phase_reg;
        retries_next    = retries_reg;
        peer_next       = peer_reg;
        scout_ctl_next  = scout_ctl_reg;
        scout_port_next = scout_port_reg;

        if (s_command || frame_ok) begin
            if (phase_reg == PHASE_IDLE) begin
                if (s_command) begin
                    spend = !forever_mode;
                end else if (s_port_byte == 8'd0) begin
                    res_cnt            = 2'd1;
                    res0.action        = ACT_REPLY;
                    res0.peer_station  = s_src_station;
                    res0.peer_network  = s_src_network;
                    res0.reply_data    = (s_ctl_byte == PEEK_CTL) ? peek_reply_reg : 32'd0;
                end else if (rejected) begin
                    spend = !forever_mode;
                end else begin
                    res_cnt           = 2'd1;
                    res0.action       = ACT_ACK;
                    res0.peer_station = s_src_station;
                    res0.peer_network = s_src_network;
                    peer_next         = src_addr;
                    scout_ctl_next    = s_ctl_byte;
                    scout_port_next   = s_port_byte;
                    phase_next        = PHASE_DATA;
                    retries_next      = retry_limit_reg;
                end
                if (spend) begin
                    if (exhausted) begin
                        retries_next = retry_limit_reg;
                        res_cnt      = 2'd1;
                        res0.action  = ACT_TIMEOUT;
                    end else begin
                        retries_next = retries_reg - 8'd1;
                    end
                end
            end else begin
                res0.peer_station = peer_reg[7:0];
                res0.peer_network = peer_reg[15:8];
                res_cnt           = 2'd1;
                res0.action       = ACT_ACK;
                if (!s_command && src_addr == peer_reg) begin
                    res_cnt           = 2'd2;
                    res1.action       = ACT_DELIVER;
                    res1.peer_station = peer_reg[7:0];
                    res1.peer_network = peer_reg[15:8];
                    res1.control      = scout_ctl_reg;
                    res1.port         = scout_port_reg;
                    res1.data_length  = s_frame_length;
                    phase_next        = PHASE_IDLE;
                    retries_next      = retry_limit_reg;
                end else if (exhausted) begin
                    res0.action  = ACT_TIMEOUT;
                    phase_next   = PHASE_IDLE;
                    retries_next = retry_limit_reg;
                end else begin
                    retries_next = retries_reg - 8'd1;
                end
            end
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = 1'b1;

        count_next = count_reg - (QUEUE_AW+1)'(pop)
                     + (accept ? (QUEUE_AW+1)'(res_cnt) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg    <= OWN_ADDR_RESET;
            wanted_station_reg <= 8'd0;
            wanted_network_reg <= 8'd0;
            wanted_port_reg    <= 8'd0;
            retry_limit_reg    <= RETRY_RESET;
            peek_reply_reg     <= 32'd0;
            phase_reg          <= PHASE_IDLE;
            retries_reg        <= RETRY_RESET;
            peer_reg           <= 16'd0;
            scout_ctl_reg      <= 8'd0;
            scout_port_reg     <= 8'd0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                peer_reg       <= peer_next;
                scout_ctl_reg  <= scout_ctl_next;
                scout_port_reg <= scout_port_next;
                wr_ptr_reg     <= wr_ptr_reg + QUEUE_AW'(res_cnt);
            end
            if (cfg_wr_en && cfg_index == REG_RETRY_LIMIT && phase_reg == PHASE_IDLE) begin
                retries_reg <= cfg_data[7:0];
            end else if (accept) begin
                retries_reg <= retries_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OWN_ADDRESS:    own_address_reg    <= cfg_data[15:0];
                    REG_WANTED_STATION: wanted_station_reg <= cfg_data[7:0];
                    REG_WANTED_NETWORK: wanted_network_reg <= cfg_data[7:0];
                    REG_WANTED_PORT:    wanted_port_reg    <= cfg_data[7:0];
                    REG_RETRY_LIMIT:    retry_limit_reg    <= cfg_data[7:0];
                    REG_PEEK_REPLY:     peek_reply_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // result queue payload
    always_ff @(posedge aclk) begin
        if (accept && res_cnt != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (accept && res_cnt == 2'd2) begin
            fifo_reg[wr_ptr_reg + QUEUE_AW'(1)] <= res1;
        end
    end

    assign head           = fifo_reg[rd_ptr_reg];
    assign m_action       = head.action;
    assign m_peer_station = head.peer_station;
    assign m_peer_network = head.peer_network;
    assign m_control      = head.control;
    assign m_port         = head.port;
    assign m_data_length  = head.data_length;
    assign m_reply_data   = head.reply_data;
    assign m_last         = head.last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_deliver_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PHASE_DATA && res_cnt == 2'd2) |=> (phase_reg == PHASE_IDLE))
        else $error("delivery did not return to idle");

    a_scout_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PHASE_IDLE && res_cnt == 2'd1 && res0.action == ACT_ACK)
        |=> (phase_reg == PHASE_DATA))
        else $error("scout ack did not enter data phase");

    a_timeout_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_cnt == 2'd1 && res0.action == ACT_TIMEOUT)
        |=> (phase_reg == PHASE_IDLE && retries_reg == $past(retry_limit_reg)))
        else $error("timeout did not reload");

endmodule
